@@ src/mchist_pkg.sv @@
`default_nettype none
package mchist_pkg;
  localparam int unsigned DefNumVertices = 65536;
  localparam int unsigned DefNumSets     = 65536;
  localparam int unsigned CntW  = 32;
  localparam int unsigned IdW   = 16;
  localparam int unsigned TotW  = 17;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned QDepth = 2;
  localparam logic [CntW-1:0] CntMax = '1;

  // apb register map
  localparam logic [1:0] AddrLastSeed = 2'd0;

  localparam logic [ReqW-1:0] ReqCountAll   = 3'd0;
  localparam logic [ReqW-1:0] ReqCountUncov = 3'd1;
  localparam logic [ReqW-1:0] ReqMark       = 3'd2;
  localparam logic [ReqW-1:0] ReqAddPartial = 3'd3;
  localparam logic [ReqW-1:0] ReqReport     = 3'd4;
  localparam logic [ReqW-1:0] ReqClrCounts  = 3'd5;
  localparam logic [ReqW-1:0] ReqClrCover   = 3'd6;

  // classified command travelling from front to back
  typedef enum logic [2:0] {
    OpNone, OpBump, OpBumpUncov, OpMark, OpReport, OpClrCounts, OpClrCover
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdW-1:0]  set_id;
    logic [IdW-1:0]  vertex;
    logic [CntW-1:0] amount;
  } cmd_t;
endpackage
`default_nettype wire

@@ src/mchist_ram.sv @@
`default_nettype none
module mchist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/mchist_front.sv @@
`default_nettype none
module mchist_front import mchist_pkg::*; #(
  parameter int unsigned NumVertices = DefNumVertices,
  parameter int unsigned NumSets     = DefNumSets
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [ReqW-1:0] req_type_i,
  input  wire logic [IdW-1:0]  set_id_i,
  input  wire logic [IdW-1:0]  vertex_i,
  input  wire logic [CntW-1:0] amount_i,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_pop_i,
  output cmd_t                 cmd_o
);
  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            q_mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  cmd_t            cls;
  logic            v_ok, s_ok, push;

  // classification: out-of-range and no-op requests are dropped here
  always_comb begin
    v_ok = {9'd0, vertex_i} < 25'(NumVertices);
    s_ok = {9'd0, set_id_i} < 25'(NumSets);
    cls.op     = OpNone;
    cls.set_id = set_id_i;
    cls.vertex = vertex_i;
    cls.amount = amount_i;
    case (req_type_i)
      ReqCountAll: begin
        if (v_ok) cls.op = OpBump;
        cls.amount = 32'd1;
      end
      ReqCountUncov: begin
        if (v_ok && s_ok) cls.op = OpBumpUncov;
        cls.amount = 32'd1;
      end
      ReqMark:       if (s_ok) cls.op = OpMark;
      ReqAddPartial: if (v_ok && amount_i != '0) cls.op = OpBump;
      ReqReport:     cls.op = OpReport;
      ReqClrCounts:  cls.op = OpClrCounts;
      ReqClrCover:   cls.op = OpClrCover;
      default:       cls.op = OpNone;
    endcase
  end

  assign in_stall_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign push        = in_valid_i && !in_stall_o && cls.op != OpNone;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_q];

  // command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_q] <= cls;
  end
endmodule
`default_nettype wire

@@ src/mchist_back.sv @@
`default_nettype none
module mchist_back import mchist_pkg::*; #(
  parameter int unsigned NumVertices = DefNumVertices,
  parameter int unsigned NumSets     = DefNumSets
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [IdW-1:0]  last_seed_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_pop_o,
  input  wire cmd_t            cmd_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [IdW-1:0]       best_vertex_o,
  output logic [CntW-1:0]      best_count_o,
  output logic [TotW-1:0]      covered_sets_o
);
  localparam int unsigned VAw = $clog2(NumVertices);
  localparam int unsigned SAw = $clog2(NumSets);
  localparam int unsigned MaxN = (NumVertices > NumSets) ? NumVertices : NumSets;
  localparam int unsigned PW = $clog2(MaxN);

  typedef enum logic [2:0] {StInit, StIdle, StRead, StWrite, StClrCnt, StClrCov} state_e;

  state_e          state_q;
  logic [PW-1:0]   ptr_q;
  cmd_t            cur_q;
  logic [IdW-1:0]  best_v_q;
  logic [CntW-1:0] best_c_q;
  logic [TotW-1:0] tot_q;

  logic            cnt_we, cov_we;
  logic [VAw-1:0]  cnt_addr;
  logic [SAw-1:0]  cov_addr;
  logic [CntW-1:0] cnt_wdata, cnt_rdata;
  logic            cov_wdata, cov_rdata;
  logic [CntW:0]   sum;
  logic [CntW-1:0] sat;
  logic            report_take;

  // saturating add on the counter read back
  assign sum = {1'b0, cnt_rdata} + {1'b0, cur_q.amount};
  assign sat = sum[CntW] ? CntMax : sum[CntW-1:0];

  always_comb begin
    cnt_we    = 1'b0;
    cov_we    = 1'b0;
    cnt_wdata = sat;
    cov_wdata = 1'b1;
    cnt_addr  = cur_q.vertex[VAw-1:0];
    cov_addr  = cur_q.set_id[SAw-1:0];
    case (state_q)
      StInit, StClrCnt, StClrCov: begin
        cnt_addr  = ptr_q[VAw-1:0];
        cov_addr  = ptr_q[SAw-1:0];
        cnt_wdata = '0;
        cov_wdata = 1'b0;
        cnt_we = (state_q != StClrCov) && ({1'b0, ptr_q} < (PW+1)'(NumVertices));
        cov_we = (state_q != StClrCnt) && ({1'b0, ptr_q} < (PW+1)'(NumSets));
      end
      StIdle: begin
        cnt_addr = cmd_i.vertex[VAw-1:0];
        cov_addr = cmd_i.set_id[SAw-1:0];
      end
      StWrite: begin
        cnt_we = (cur_q.op == OpBump) || (cur_q.op == OpBumpUncov && !cov_rdata);
        cov_we = (cur_q.op == OpMark) && !cov_rdata && cur_q.vertex == last_seed_i;
      end
      default: ;
    endcase
  end

  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i &&
                     !(cmd_i.op == OpReport && out_valid_o && out_stall_i);
  assign report_take = cmd_pop_o && (cmd_i.op == OpReport);

  mchist_ram #(.Width(CntW), .Depth(NumVertices)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_addr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_addr), .rdata_o(cnt_rdata));

  mchist_ram #(.Width(1), .Depth(NumSets)) u_cov (
    .clk_i, .we_i(cov_we), .waddr_i(cov_addr), .wdata_i(cov_wdata),
    .raddr_i(cov_addr), .rdata_o(cov_rdata));

  // sequencer: read-modify-write, clear walks, report register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StInit;
      ptr_q          <= '0;
      best_v_q       <= '0;
      best_c_q       <= '0;
      tot_q          <= '0;
      out_valid_o    <= 1'b0;
      best_vertex_o  <= '0;
      best_count_o   <= '0;
      covered_sets_o <= '0;
    end else begin
      // result register: load on a report, drop after its transfer
      if (report_take) begin
        out_valid_o    <= 1'b1;
        best_vertex_o  <= best_v_q;
        best_count_o   <= best_c_q;
        covered_sets_o <= tot_q;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StInit, StClrCnt, StClrCov: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == PW'(((state_q == StClrCnt) ? NumVertices :
                            (state_q == StClrCov) ? NumSets : MaxN) - 1)) begin
            state_q <= StIdle;
            ptr_q   <= '0;
          end
        end
        StIdle: begin
          if (cmd_pop_o) begin
            case (cmd_i.op)
              OpReport: ;
              OpClrCounts: begin
                best_v_q <= '0;
                best_c_q <= '0;
                state_q  <= StClrCnt;
              end
              OpClrCover: begin
                tot_q   <= '0;
                state_q <= StClrCov;
              end
              default: state_q <= StRead;
            endcase
          end
        end
        StRead: state_q <= StWrite;
        StWrite: begin
          if (cnt_we && (sat > best_c_q || (sat == best_c_q && cur_q.vertex < best_v_q))) begin
            best_c_q <= sat;
            best_v_q <= cur_q.vertex;
          end
          if (cov_we) tot_q <= tot_q + 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
  end
endmodule
`default_nettype wire

@@ src/masked_coverage_histogram_argmax_unit.sv @@
// a report request passes through the command queue, then loads the result register once
// the back end is idle and no earlier result is stalled; count and mark requests step the
// back end through issue, read and modify-write, one at a time, for the registered-read memory
// clear counts walks every vertex counter, clear cover walks every set flag
// reset: asynchronous active low; a clearing pass over both memories follows,
// during which up to two requests queue and then input stalls
`default_nettype none
module masked_coverage_histogram_argmax_unit import mchist_pkg::*; #(
  parameter int unsigned NUM_VERTICES = DefNumVertices,
  parameter int unsigned NUM_SETS     = DefNumSets
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [1:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [ReqW-1:0] req_type_i,
  input  wire logic [IdW-1:0]  set_id_i,
  input  wire logic [IdW-1:0]  vertex_i,
  input  wire logic [CntW-1:0] amount_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [IdW-1:0]       best_vertex_o,
  output logic [CntW-1:0]      best_count_o,
  output logic [TotW-1:0]      covered_sets_o
);
  logic [IdW-1:0] last_seed_q;
  logic           cmd_valid, cmd_pop;
  cmd_t           cmd;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == AddrLastSeed) ? {16'd0, last_seed_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seed_q <= '0;
    end else if (psel && penable && pwrite && paddr == AddrLastSeed) begin
      last_seed_q <= pwdata[IdW-1:0];
    end
  end

  mchist_front #(.NumVertices(NUM_VERTICES), .NumSets(NUM_SETS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .set_id_i,
    .vertex_i, .amount_i, .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd));

  mchist_back #(.NumVertices(NUM_VERTICES), .NumSets(NUM_SETS)) u_back (
    .clk_i, .rst_ni, .last_seed_i(last_seed_q), .cmd_valid_i(cmd_valid),
    .cmd_pop_o(cmd_pop), .cmd_i(cmd), .out_valid_o, .out_stall_i,
    .best_vertex_o, .best_count_o, .covered_sets_o);
endmodule
`default_nettype wire

@@ src/mchist_checker.sv @@
`default_nettype none
module mchist_checker import mchist_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [CntW-1:0] best_count_o,
  input wire logic [TotW-1:0] covered_sets_o,
  input wire logic            pready
);
  // a stalled result holds its count
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(best_count_o) && $stable(covered_sets_o))
    else $error("result changed under stall");

  // a pending result stays valid
  a_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped");

  // no result right after reset
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result out of reset");

  // apb never waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind masked_coverage_histogram_argmax_unit mchist_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_masked_coverage_histogram_argmax_unit.sv @@
`timescale 1ns / 100ps
module tb_masked_coverage_histogram_argmax_unit;
  import mchist_pkg::*;

  localparam logic [ReqW-1:0] ReqUnused = 3'd7;
  localparam int unsigned SettleCycles = 10;

  typedef struct {
    logic [ReqW-1:0] req;
    logic [IdW-1:0]  set_id;
    logic [IdW-1:0]  vertex;
    logic [CntW-1:0] amount;
  } request_t;

  typedef struct {
    logic [IdW-1:0]  best_vertex;
    logic [CntW-1:0] best_count;
    logic [TotW-1:0] covered_sets;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ReqW-1:0] req_type_i = '0;
  logic [IdW-1:0] set_id_i = '0;
  logic [IdW-1:0] vertex_i = '0;
  logic [CntW-1:0] amount_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IdW-1:0] best_vertex_o;
  logic [CntW-1:0] best_count_o;
  logic [TotW-1:0] covered_sets_o;

  masked_coverage_histogram_argmax_unit uut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scoreboard state and predictor copy of the block
  request_t pending_reqs[$];
  report_t expected_reports[$];
  logic [CntW-1:0] vertex_count[int unsigned];
  bit set_done[int unsigned];
  logic [IdW-1:0] best_vtx, seed;
  logic [CntW-1:0] best_cnt;
  logic [TotW-1:0] covered_cnt;
  int send_idle_pct = 38, recv_idle_pct = 73;
  int errors = 0, reports_seen = 0, reqs_taken = 0, clears_left = 3;
  bit in_took = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void bump_count(logic [IdW-1:0] v, logic [CntW-1:0] inc);
    logic [CntW:0] sum;
    logic [CntW-1:0] c;
    if (inc == '0) return;
    sum = {1'b0, (vertex_count.exists(v) ? vertex_count[v] : {CntW{1'b0}})} +
          {1'b0, inc};
    c = sum[CntW] ? CntMax : sum[CntW-1:0];
    vertex_count[v] = c;
    if (c > best_cnt || (c == best_cnt && v < best_vtx)) begin
      best_cnt = c;
      best_vtx = v;
    end
  endfunction

  function automatic void predict_request(request_t r);
    case (r.req)
      ReqCountAll: bump_count(r.vertex, 1);
      ReqCountUncov: if (!set_done.exists(r.set_id)) bump_count(r.vertex, 1);
      ReqMark: if (r.vertex == seed && !set_done.exists(r.set_id)) begin
        set_done[r.set_id] = 1'b1;
        covered_cnt++;
      end
      ReqAddPartial: bump_count(r.vertex, r.amount);
      ReqReport: expected_reports.push_back('{best_vtx, best_cnt, covered_cnt});
      ReqClrCounts: begin
        vertex_count.delete();
        best_vtx = '0;
        best_cnt = '0;
      end
      ReqClrCover: begin
        set_done.delete();
        covered_cnt = '0;
      end
      default: ;
    endcase
  endfunction

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk_i) begin
    report_t want;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      predict_request('{req_type_i, set_id_i, vertex_i, amount_i});
      reqs_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report", best_vertex_o, 0);
      end else begin
        want = expected_reports.pop_front();
        if (best_vertex_o !== want.best_vertex)
          report_mismatch("best_vertex", best_vertex_o, want.best_vertex);
        if (best_count_o !== want.best_count)
          report_mismatch("best_count", best_count_o, want.best_count);
        if (covered_sets_o !== want.covered_sets)
          report_mismatch("covered_sets", covered_sets_o, want.covered_sets);
      end
    end
  end

  // driver: hold a stalled request, otherwise maybe idle, else send the next one
  always @(negedge clk_i) begin
    request_t r;
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if (!in_valid_i || in_took) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= r.req;
        set_id_i <= r.set_id;
        vertex_i <= r.vertex;
        amount_i <= r.amount;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic queue_req(logic [ReqW-1:0] req, logic [IdW-1:0] s,
                           logic [IdW-1:0] v, logic [CntW-1:0] amt);
    pending_reqs.push_back('{req, s, v, amt});
  endtask

  // apb write, setup then access
  task automatic write_seed(logic [IdW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrLastSeed;
    pwdata <= {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    seed = value;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic request_t random_req();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.set_id = ($urandom_range(9) < 8) ? IdW'($urandom_range(31)) : IdW'($urandom);
    r.vertex = ($urandom_range(9) < 8) ? IdW'($urandom_range(15)) : IdW'($urandom);
    case ($urandom_range(3))
      0: r.amount = $urandom_range(20);
      1: r.amount = CntMax - $urandom_range(15);
      default: r.amount = $urandom;
    endcase
    if (pick < 25) r.req = ReqCountAll;
    else if (pick < 50) r.req = ReqCountUncov;
    else if (pick < 70) begin
      r.req = ReqMark;
      if ($urandom_range(9) < 7) r.vertex = seed;
    end else if (pick < 85) r.req = ReqAddPartial;
    else if (pick < 96) r.req = ReqReport;
    else if (pick < 98) r.req = ReqUnused;
    else if (clears_left > 0) begin
      clears_left--;
      r.req = pick[0] ? ReqClrCounts : ReqClrCover;
    end else r.req = ReqReport;
    return r;
  endfunction

  task automatic random_phase(int n, int s_idle, int r_idle, logic [IdW-1:0] new_seed);
    write_seed(new_seed);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) pending_reqs.push_back(random_req());
    queue_req(ReqReport, 0, 0, 0);
    wait_drained();
  endtask

  initial begin
    best_vtx = '0;
    best_cnt = '0;
    covered_cnt = '0;
    seed = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, saturation, ties, covered sets, unused code, clears
    write_seed(16'hFFFF);
    queue_req(ReqReport, 0, 0, 0);
    queue_req(ReqCountAll, 0, 0, 0);
    queue_req(ReqCountAll, 16'hFFFF, 16'hFFFF, CntMax);
    queue_req(ReqAddPartial, 0, 5, CntMax);
    queue_req(ReqAddPartial, 0, 5, CntMax);
    queue_req(ReqAddPartial, 0, 7, 0);
    queue_req(ReqReport, 0, 0, 0);
    queue_req(ReqMark, 16'hFFFF, 16'hFFFF, 0);
    queue_req(ReqMark, 16'hFFFF, 16'hFFFF, 0);
    queue_req(ReqMark, 0, 16'h1234, 0);
    queue_req(ReqCountUncov, 16'hFFFF, 9, 0);
    queue_req(ReqCountUncov, 0, 9, 0);
    queue_req(ReqReport, 0, 0, 0);
    queue_req(ReqUnused, 16'hFFFF, 16'hFFFF, CntMax);
    queue_req(ReqClrCounts, 0, 0, 0);
    queue_req(ReqReport, 0, 0, 0);
    queue_req(ReqAddPartial, 0, 10, 3);
    queue_req(ReqAddPartial, 0, 4, 3);
    queue_req(ReqReport, 0, 0, 0);
    queue_req(ReqClrCover, 0, 0, 0);
    queue_req(ReqReport, 0, 0, 0);
    wait_drained();

    random_phase(170, 38, 73, 16'd0);
    random_phase(170, 73, 38, IdW'($urandom_range(15)));
    random_phase(170, 0, 0, 16'd3);

    $display("covered %0d requests and %0d reports over seeds and three idle patterns",
             reqs_taken, reports_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("timeout with %0d reports outstanding", expected_reports.size());
    $display("status: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
src/mchist_pkg.sv
src/mchist_ram.sv
src/mchist_front.sv
src/mchist_back.sv
src/masked_coverage_histogram_argmax_unit.sv
src/mchist_checker.sv
tb/sv/tb_masked_coverage_histogram_argmax_unit.sv
